// ----- hdl/bsf_pkg.sv -----
// Shared types and constants for the Bezier segment flattener.
// Used by bsf_front, bsf_queue, bsf_back and bezier_segment_flattener_top; no dependencies.
package bsf_pkg;

	localparam int CoordBits  = 16;
	localparam int PointBits  = 20;
	localparam int WeightBits = 7;
	localparam int NumCtrl    = 4;
	localparam int StepBits   = 4;
	localparam int PointHalf  = 524288;

	localparam logic KindQuad  = 1'b0;
	localparam logic KindCubic = 1'b1;

	localparam logic [StepBits-1:0] QuadLastStep  = 4'd9;
	localparam logic [StepBits-1:0] CubicLastStep = 4'd4;

	// sum/den -> floor((32*sum + den) / (2*den)); 2*den = 8*25 or 2*125
	localparam logic [6:0] QuadDiv    = 7'd25;
	localparam logic [6:0] CubicDiv   = 7'd125;
	localparam logic [6:0] QuadDen    = 7'd100;
	localparam logic [6:0] CubicDen   = 7'd125;
	localparam int         RecipShift = 34;
	localparam int         RecipBits  = 30;
	localparam logic [RecipBits-1:0] QuadRecip  = 30'd687194767;
	localparam logic [RecipBits-1:0] CubicRecip = 30'd137438953;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic [StepBits-1:0] step_t;
	typedef logic [WeightBits-1:0] weight_t;
	typedef weight_t [NumCtrl-1:0] weight_set_t;

	typedef struct packed {
		logic   kind;
		coord_t start_x;
		coord_t start_y;
		coord_t ctrl1_x;
		coord_t ctrl1_y;
		coord_t ctrl2_x;
		coord_t ctrl2_y;
		coord_t end_x;
		coord_t end_y;
	} segment_t;

	typedef struct packed {
		logic signed [PointBits-1:0] point_x;
		logic signed [PointBits-1:0] point_y;
		logic                        last_point;
	} point_t;

	typedef struct packed {
		logic                  cubic;
		step_t                 last_step;
		coord_t [NumCtrl-1:0]  px;
		coord_t [NumCtrl-1:0]  py;
	} seg_cmd_t;

	// Bernstein numerators, packed as {w3, w2, w1, w0}
	function automatic weight_set_t bern_weights(logic cubic, step_t i);
		weight_set_t w;
		case ({cubic, i})
			{KindQuad, 4'd1}:  w = {7'd1,  7'd0,  7'd18, 7'd81};
			{KindQuad, 4'd2}:  w = {7'd4,  7'd0,  7'd32, 7'd64};
			{KindQuad, 4'd3}:  w = {7'd9,  7'd0,  7'd42, 7'd49};
			{KindQuad, 4'd4}:  w = {7'd16, 7'd0,  7'd48, 7'd36};
			{KindQuad, 4'd5}:  w = {7'd25, 7'd0,  7'd50, 7'd25};
			{KindQuad, 4'd6}:  w = {7'd36, 7'd0,  7'd48, 7'd16};
			{KindQuad, 4'd7}:  w = {7'd49, 7'd0,  7'd42, 7'd9};
			{KindQuad, 4'd8}:  w = {7'd64, 7'd0,  7'd32, 7'd4};
			{KindQuad, 4'd9}:  w = {7'd81, 7'd0,  7'd18, 7'd1};
			{KindCubic, 4'd1}: w = {7'd1,  7'd12, 7'd48, 7'd64};
			{KindCubic, 4'd2}: w = {7'd8,  7'd36, 7'd54, 7'd27};
			{KindCubic, 4'd3}: w = {7'd27, 7'd54, 7'd36, 7'd8};
			{KindCubic, 4'd4}: w = {7'd64, 7'd48, 7'd12, 7'd1};
			default:           w = '0;
		endcase
		return w;
	endfunction

endpackage

// ----- hdl/bsf_front.sv -----
// Front end: takes segment transfers, classifies them and hands a command to the queue.
// Depends on bsf_pkg.
module bsf_front import bsf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  segment_t segment,
	input  logic     segment_valid,
	output logic     segment_stall,
	output seg_cmd_t cmd,
	output logic     cmd_valid,
	input  logic     cmd_full
);

	logic     valid_q;
	seg_cmd_t cmd_q;
	logic     accept;
	logic     push;

	assign segment_stall = valid_q && cmd_full;
	assign accept        = segment_valid && !segment_stall;
	assign push          = valid_q && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.cubic     <= segment.kind;
			cmd_q.last_step <= (segment.kind == KindCubic) ? CubicLastStep : QuadLastStep;
			cmd_q.px        <= {segment.end_x, segment.ctrl2_x, segment.ctrl1_x, segment.start_x};
			cmd_q.py        <= {segment.end_y, segment.ctrl2_y, segment.ctrl1_y, segment.start_y};
		end
	end

	assign cmd       = cmd_q;
	assign cmd_valid = valid_q;

endmodule

// ----- hdl/bsf_queue.sv -----
// Short command queue between front and back end; holds segment coordinates.
// Depends on bsf_pkg.
module bsf_queue import bsf_pkg::*; #(
	parameter int Depth = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  seg_cmd_t push_cmd,
	input  logic     push,
	output logic     full,
	output seg_cmd_t head,
	output logic     head_valid,
	input  logic     pop
);

	localparam int PtrBits   = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CountBits = $clog2(Depth + 1);

	seg_cmd_t               mem_q [Depth];
	logic [PtrBits-1:0]     wr_ptr_q;
	logic [PtrBits-1:0]     rd_ptr_q;
	logic [CountBits-1:0]   count_q;

	function automatic logic [PtrBits-1:0] ptr_next(logic [PtrBits-1:0] p);
		return (p == PtrBits'(Depth - 1)) ? '0 : p + PtrBits'(1);
	endfunction

	assign full       = (count_q == CountBits'(Depth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CountBits'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CountBits'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !head_valid))
		else $error("pop from empty queue");

endmodule

// ----- hdl/bsf_back.sv -----
// Back end: steps through the points of the head segment and evaluates each one
// in a five-stage datapath (weights, sum, scale/clamp, reciprocal, correction). Depends on bsf_pkg.
module bsf_back import bsf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  seg_cmd_t head,
	input  logic     head_valid,
	output logic     pop,
	output point_t   point,
	output logic     point_valid,
	input  logic     point_stall
);

	localparam int ProdBits  = CoordBits + WeightBits + 1;
	localparam int SumBits   = ProdBits + 2;
	localparam int NumBits   = SumBits + 6;
	localparam int CmpBits   = (NumBits > 29) ? NumBits : 29;
	localparam int ModBits   = 27;
	localparam int QuotBits  = PointBits + 1;
	localparam int FullBits  = ModBits + RecipBits;

	localparam logic signed [CmpBits-1:0] QuadLo  = CmpBits'(-(PointHalf * 25));
	localparam logic signed [CmpBits-1:0] QuadHi  = CmpBits'(PointHalf * 25 - 1);
	localparam logic signed [CmpBits-1:0] CubicLo = CmpBits'(-(PointHalf * 125));
	localparam logic signed [CmpBits-1:0] CubicHi = CmpBits'(PointHalf * 125 - 1);

	logic        adv;
	logic        issue;
	step_t       step_q;
	step_t       step_i;
	weight_set_t w;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic cubic_s1, cubic_s2, cubic_s3, cubic_s4;
	logic last_s1, last_s2, last_s3, last_s4;

	logic signed [ProdBits-1:0] prod_s1 [2][NumCtrl];
	logic signed [SumBits-1:0]  sum_s2 [2];
	logic [ModBits-1:0]         mod_s3 [2];
	logic [ModBits-1:0]         mod_s4 [2];
	logic [QuotBits-1:0]        qest_s4 [2];
	logic [ModBits:0]           rem_c [2];
	logic [QuotBits-1:0]        q_c [2];

	point_t point_q;
	logic   point_valid_q;

	assign adv    = !point_valid_q || !point_stall;
	assign issue  = adv && head_valid;
	assign step_i = step_q + StepBits'(1);
	assign pop    = issue && (step_i == head.last_step);
	assign w      = bern_weights(head.cubic, step_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			valid_s4      <= 1'b0;
			point_valid_q <= 1'b0;
		end else if (adv) begin
			if (issue) begin
				step_q <= pop ? '0 : step_i;
			end
			valid_s1      <= issue;
			valid_s2      <= valid_s1;
			valid_s3      <= valid_s2;
			valid_s4      <= valid_s3;
			point_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cubic_s1 <= head.cubic;
			last_s1  <= pop;
			cubic_s2 <= cubic_s1;
			last_s2  <= last_s1;
			cubic_s3 <= cubic_s2;
			last_s3  <= last_s2;
			cubic_s4 <= cubic_s3;
			last_s4  <= last_s3;
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_axis
		coord_t [NumCtrl-1:0]      pts;
		logic signed [NumBits-1:0] num;
		logic signed [NumBits-1:0] scaled;
		logic signed [CmpBits-1:0] ext;
		logic signed [CmpBits-1:0] lo;
		logic signed [CmpBits-1:0] hi;
		logic signed [CmpBits-1:0] clamped;
		logic [RecipBits-1:0]      recip;
		logic [FullBits-1:0]       full;
		logic [ModBits:0]          backprod;
		logic [6:0]                div;

		assign pts = (a == 0) ? head.px : head.py;

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int j = 0; j < NumCtrl; j++) begin
					prod_s1[a][j] <= $signed(pts[j]) * $signed({1'b0, w[j]});
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sum_s2[a] <= SumBits'(prod_s1[a][0]) + SumBits'(prod_s1[a][1])
					+ SumBits'(prod_s1[a][2]) + SumBits'(prod_s1[a][3]);
			end
		end

		always_comb begin
			num     = $signed({sum_s2[a], 5'b0})
				+ $signed(NumBits'(cubic_s2 ? CubicDen : QuadDen));
			scaled  = cubic_s2 ? (num >>> 1) : (num >>> 3);
			ext     = CmpBits'(scaled);
			lo      = cubic_s2 ? CubicLo : QuadLo;
			hi      = cubic_s2 ? CubicHi : QuadHi;
			if (ext < lo) begin
				clamped = lo;
			end else if (ext > hi) begin
				clamped = hi;
			end else begin
				clamped = ext;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				mod_s3[a] <= ModBits'(clamped - lo);
			end
		end

		assign recip = cubic_s3 ? CubicRecip : QuadRecip;
		assign full  = FullBits'(mod_s3[a]) * FullBits'(recip);

		always_ff @(posedge clk) begin
			if (adv) begin
				qest_s4[a] <= full[RecipShift+QuotBits-1:RecipShift];
				mod_s4[a]  <= mod_s3[a];
			end
		end

		assign div      = cubic_s4 ? CubicDiv : QuadDiv;
		assign backprod = (ModBits + 1)'(qest_s4[a]) * (ModBits + 1)'(div);
		assign rem_c[a] = {1'b0, mod_s4[a]} - backprod;
		assign q_c[a]   = qest_s4[a] + QuotBits'(rem_c[a] >= (ModBits + 1)'(div));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_q.point_x    <= {~q_c[0][PointBits-1], q_c[0][PointBits-2:0]};
			point_q.point_y    <= {~q_c[1][PointBits-1], q_c[1][PointBits-2:0]};
			point_q.last_point <= last_s4;
		end
	end

	assign point       = point_q;
	assign point_valid = point_valid_q;

	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (step_q == '0))
		else $error("step counter not idle with empty queue");
	a_pop_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (step_q == '0))
		else $error("step counter not rewound after last point");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (rem_c[0] < ((ModBits + 1)'(cubic_s4 ? CubicDiv : QuadDiv) << 1)))
		else $error("reciprocal estimate off by more than one");

endmodule

// ----- hdl/bezier_segment_flattener_top.sv -----
// Top level of the Bezier segment flattener: front end, command queue, back end.
// Depends on bsf_pkg, bsf_front, bsf_queue, bsf_back.
//
// Each segment transfer yields its interior curve points, one point transfer per
// cycle while the output is not stalled: 9 points for a quadratic (t = i/10) and
// 4 for a cubic (t = i/5), the last one flagged by last_point. A segment holds the
// point sequencer of the back end until its last point is issued, which sets the
// sustained rate. A segment passes the front register and the queue, each point
// then the back end stages s1 to s4 and the point register. Points carry 4 fractional
// bits, rounded half up and saturated to 20 bits. The queue of QUEUE_DEPTH segments
// plus the front register lets new segments be taken while points are being produced.
module bezier_segment_flattener_top import bsf_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  segment_t segment,
	input  logic     segment_valid,
	output logic     segment_stall,
	output point_t   point,
	output logic     point_valid,
	input  logic     point_stall
);

	seg_cmd_t cmd;
	logic     cmd_valid;
	logic     cmd_full;
	seg_cmd_t head;
	logic     head_valid;
	logic     pop;

	bsf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.segment       (segment),
		.segment_valid (segment_valid),
		.segment_stall (segment_stall),
		.cmd           (cmd),
		.cmd_valid     (cmd_valid),
		.cmd_full      (cmd_full)
	);

	bsf_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (cmd),
		.push       (cmd_valid && !cmd_full),
		.full       (cmd_full),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	bsf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.point       (point),
		.point_valid (point_valid),
		.point_stall (point_stall)
	);

endmodule

// ----- test/bezier_segment_flattener_checker.sv -----
// Checker for the Bezier segment flattener: watches both channels, predicts the curve points
// of each segment transfer and compares every point transfer against them in order.
// Depends on bsf_pkg.
module bezier_segment_flattener_checker import bsf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  segment_t segment,
	input  logic     segment_valid,
	input  logic     segment_stall,
	input  point_t   point,
	input  logic     point_valid,
	input  logic     point_stall,
	output int       mismatches,
	output int       pending,
	output int       checked
);

	point_t curve_points[$];
	int     n_bad = 0;
	int     n_ok  = 0;

	// 16*sum/den rounded half up, saturated to the point width
	function automatic logic signed [PointBits-1:0] round_q4(input longint sum,
			input longint den);
		longint num;
		longint dd;
		longint q;
		num = sum * 32 + den;
		dd  = den * 2;
		q   = num / dd;
		if ((num % dd) != 0 && num < 0)
			q = q - 1;
		if (q < -longint'(PointHalf))
			q = -longint'(PointHalf);
		if (q > longint'(PointHalf) - 1)
			q = longint'(PointHalf) - 1;
		return q[PointBits-1:0];
	endfunction

	function automatic void queue_curve_points(input segment_t s);
		longint xs[4];
		longint ys[4];
		longint w[4];
		longint sx;
		longint sy;
		longint den;
		longint u;
		int     count;
		int     i;
		int     k;
		point_t p;
		xs[0] = longint'($signed(s.start_x));
		ys[0] = longint'($signed(s.start_y));
		xs[1] = longint'($signed(s.ctrl1_x));
		ys[1] = longint'($signed(s.ctrl1_y));
		xs[2] = longint'($signed(s.ctrl2_x));
		ys[2] = longint'($signed(s.ctrl2_y));
		xs[3] = longint'($signed(s.end_x));
		ys[3] = longint'($signed(s.end_y));
		count = (s.kind == KindCubic) ? 4 : 9;
		for (i = 1; i <= count; i++) begin
			if (s.kind == KindCubic) begin
				u    = 5 - i;
				w[0] = u * u * u;
				w[1] = 3 * i * u * u;
				w[2] = 3 * i * i * u;
				w[3] = i * i * i;
				den  = 125;
			end else begin
				// ctrl2 carries no weight for a quadratic
				u    = 10 - i;
				w[0] = u * u;
				w[1] = 2 * i * u;
				w[2] = 0;
				w[3] = i * i;
				den  = 100;
			end
			sx = 0;
			sy = 0;
			for (k = 0; k < 4; k++) begin
				sx += w[k] * xs[k];
				sy += w[k] * ys[k];
			end
			p.point_x    = round_q4(sx, den);
			p.point_y    = round_q4(sy, den);
			p.last_point = (i == count);
			curve_points.insert(curve_points.size(), p);
		end
	endfunction

	always @(posedge clk) begin
		point_t want;
		if (arst_n) begin
			if (segment_valid && !segment_stall)
				queue_curve_points(segment);
			if (point_valid && !point_stall) begin
				if (curve_points.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected point transfer: x=%0d y=%0d last=%0b",
							point.point_x, point.point_y, point.last_point);
				end else begin
					want = curve_points.pop_front();
					n_ok++;
					if (point.point_x !== want.point_x || point.point_y !== want.point_y ||
							point.last_point !== want.last_point) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"point %0d mismatch: expected x=%0d y=%0d last=%0b,",
								" got x=%0d y=%0d last=%0b"},
								n_ok, want.point_x, want.point_y, want.last_point,
								point.point_x, point.point_y, point.last_point);
					end
				end
			end
		end
		mismatches <= n_bad;
		pending    <= curve_points.size();
		checked    <= n_ok;
	end

endmodule

// ----- test/bezier_segment_flattener_top_tb.sv -----
// Testbench top for the Bezier segment flattener: directed and random segments sent in bursts,
// output stalled on a changing pattern, verdict from the checker's counts.
// Depends on bsf_pkg, bezier_segment_flattener_top and bezier_segment_flattener_checker.
module bezier_segment_flattener_top_tb;
	import bsf_pkg::*;

	localparam int     CycleLimit  = 400000;
	localparam int     RandomItems = 300;
	localparam coord_t CoordMax    = 16'sh7fff;
	localparam coord_t CoordMin    = 16'sh8000;

	typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_t;

	logic     clk           = 1'b0;
	logic     arst_n        = 1'b0;
	segment_t segment       = '0;
	logic     segment_valid = 1'b0;
	logic     segment_stall;
	point_t   point;
	logic     point_valid;
	logic     point_stall   = 1'b0;

	int mismatches;
	int pending;
	int checked;
	int cycles  = 0;
	int n_quad  = 0;
	int n_cubic = 0;

	stall_mode_t stall_mode = StallNone;
	int          stall_left = 0;
	logic [3:0]  stall_phase = '0;

	bezier_segment_flattener_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.segment       (segment),
		.segment_valid (segment_valid),
		.segment_stall (segment_stall),
		.point         (point),
		.point_valid   (point_valid),
		.point_stall   (point_stall)
	);

	bezier_segment_flattener_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.segment       (segment),
		.segment_valid (segment_valid),
		.segment_stall (segment_stall),
		.point         (point),
		.point_valid   (point_valid),
		.point_stall   (point_stall),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycles < CycleLimit)
			@(posedge clk) cycles++;
		$display("timeout after %0d cycles, %0d points still expected", cycles, pending);
		$display("bezier_segment_flattener_top test failed");
		$finish;
	end

	// output stall pattern: mode is redrawn whenever its random countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(50, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= stall_phase + 4'd1;
		case (stall_mode)
			StallNone:  point_stall <= 1'b0;
			StallLight: point_stall <= ($urandom_range(0, 2) == 0);
			StallHeavy: point_stall <= ($urandom_range(0, 3) != 0);
			default:    point_stall <= stall_phase[2];
		endcase
	end

	function automatic segment_t make_segment(input logic kind, input coord_t sx, input coord_t sy,
			input coord_t c1x, input coord_t c1y, input coord_t c2x, input coord_t c2y,
			input coord_t ex, input coord_t ey);
		segment_t s;
		s.kind    = kind;
		s.start_x = sx;
		s.start_y = sy;
		s.ctrl1_x = c1x;
		s.ctrl1_y = c1y;
		s.ctrl2_x = c2x;
		s.ctrl2_y = c2y;
		s.end_x   = ex;
		s.end_y   = ey;
		return s;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0:       return CoordMax;
			1:       return CoordMin;
			2, 3:    return coord_t'(int'($urandom_range(0, 40)) - 20);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// holds valid until the transfer; valid stays high for a following item
	task automatic send_segment(input segment_t s);
		segment       <= s;
		segment_valid <= 1'b1;
		do
			@(posedge clk);
		while (segment_stall);
		if (s.kind == KindCubic)
			n_cubic++;
		else
			n_quad++;
	endtask

	task automatic drain_points();
		segment_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int       burst_left;
		int       gap;
		int       n;
		segment_t s;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		send_segment(make_segment(KindQuad, 0, 0, 0, 0, 0, 0, 0, 0));
		send_segment(make_segment(KindCubic, 0, 0, 0, 0, 0, 0, 0, 0));
		send_segment(make_segment(KindQuad, CoordMax, CoordMax, CoordMax, CoordMax,
			CoordMax, CoordMax, CoordMax, CoordMax));
		send_segment(make_segment(KindCubic, CoordMax, CoordMax, CoordMax, CoordMax,
			CoordMax, CoordMax, CoordMax, CoordMax));
		send_segment(make_segment(KindQuad, CoordMin, CoordMin, CoordMin, CoordMin,
			CoordMin, CoordMin, CoordMin, CoordMin));
		send_segment(make_segment(KindCubic, CoordMin, CoordMin, CoordMin, CoordMin,
			CoordMin, CoordMin, CoordMin, CoordMin));
		send_segment(make_segment(KindQuad, CoordMax, CoordMin, CoordMin, CoordMax,
			CoordMax, CoordMin, CoordMin, CoordMax));
		send_segment(make_segment(KindCubic, CoordMin, CoordMax, CoordMax, CoordMin,
			CoordMin, CoordMax, CoordMax, CoordMin));
		send_segment(make_segment(KindCubic, CoordMax, CoordMin, CoordMin, CoordMax,
			CoordMax, CoordMin, CoordMin, CoordMax));
		// small values: rounding on both sides of zero
		send_segment(make_segment(KindQuad, -1, -1, 0, 0, 0, 0, 0, 0));
		send_segment(make_segment(KindQuad, 1, 1, 0, 0, 0, 0, 0, 0));
		send_segment(make_segment(KindCubic, 0, 0, -1, 1, 0, 0, 0, 0));
		send_segment(make_segment(KindCubic, 0, 0, 0, 0, 1, -1, 0, 0));
		send_segment(make_segment(KindCubic, 0, 0, 0, 0, 0, 0, -7, 7));
		// quadratic must ignore ctrl2
		send_segment(make_segment(KindQuad, 0, 0, -3, 5, CoordMin, CoordMax, 0, 0));
		send_segment(make_segment(KindQuad, 0, 0, 0, 0, 0, 0, CoordMax, CoordMin));
		send_segment(make_segment(KindCubic, 0, 0, 0, 0, 0, 0, CoordMax, CoordMin));
		drain_points();

		burst_left = 0;
		for (n = 0; n < RandomItems; n++) begin
			if (n == RandomItems / 2)
				drain_points();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				if (gap != 0) begin
					segment_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			s = make_segment(logic'($urandom_range(0, 1)), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord());
			send_segment(s);
		end

		drain_points();
		repeat (40) @(posedge clk);

		$display("sent %0d segments (%0d quadratic, %0d cubic), checked %0d points",
			n_quad + n_cubic, n_quad, n_cubic, checked);
		$display("input in bursts with gaps and drains, output under none/light/heavy/periodic stall");
		if (mismatches == 0 && pending == 0)
			$display("bezier_segment_flattener_top test passed");
		else
			$display("bezier_segment_flattener_top test failed");
		$finish;
	end

endmodule
